/* rtl/json_data_object_extractor_defines.svh */
// Assertion macros for the JSON object extractor.
// Both expect clk_i and rst_ni in scope at the point of use.
`ifndef JSON_DATA_OBJECT_EXTRACTOR_DEFINES_SVH
`define JSON_DATA_OBJECT_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define JDOE_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("jdoe assertion failed");
// checked at every edge, reset included
`define JDOE_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("jdoe assertion failed");
`else
`define JDOE_ASSERT(label, prop)
`define JDOE_ASSERT_ALWAYS(label, prop)
`endif

`endif

/* rtl/jdoe_pkg.sv */
package jdoe_pkg;

  localparam int unsigned PayloadCap   = 256;
  localparam int unsigned TextBufSize  = 1024;
  localparam int unsigned KeyLen       = 7;

  localparam int unsigned KeptW = $clog2(PayloadCap);
  localparam int unsigned PosW  = $clog2(TextBufSize);

  localparam logic [7:0] ChOpen  = 8'h7B;  // '{'
  localparam logic [7:0] ChClose = 8'h7D;  // '}'
  localparam logic [7:0] ChSpace = 8'h20;  // ' '
  localparam logic [7:0] ChQuote = 8'h22;  // '"'
  localparam logic [7:0] ChD     = 8'h44;  // 'D'

  typedef enum logic [3:0] {
    PhKey   = 4'b0001,
    PhSpace = 4'b0010,
    PhCopy  = 4'b0100,
    PhDone  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       frame_end;
  } jdoe_in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [7:0] payload_index;
    logic       done_res;
    logic       found;
    logic [7:0] payload_length;
  } jdoe_out_t;

  // characters of the key "DATA": in match order
  function automatic logic [7:0] key_char(logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = ChQuote;
      3'd1:    ch = ChD;
      3'd2:    ch = 8'h41;  // 'A'
      3'd3:    ch = 8'h54;  // 'T'
      3'd4:    ch = 8'h41;  // 'A'
      3'd5:    ch = ChQuote;
      3'd6:    ch = 8'h3A;  // ':'
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/jdoe_scan.sv */
module jdoe_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  jdoe_pkg::jdoe_in_t  item_i,
  output jdoe_pkg::jdoe_out_t res_o
);
  import jdoe_pkg::*;

  phase_e           phase_q, phase_d;
  logic [2:0]       match_q, match_d;
  logic [PosW-1:0]  depth_q, depth_d;
  logic [KeptW-1:0] kept_q,  kept_d;
  logic [PosW-1:0]  pos_q,   pos_d;
  logic             over_q,  over_d;

  logic [7:0] c;
  logic       in_text;
  logic       closed;
  logic [2:0] j;

  assign c = item_i.text_byte;

  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    depth_d = depth_q;
    kept_d  = kept_q;
    pos_d   = pos_q;
    over_d  = over_q;
    res_o   = '0;
    closed  = 1'b0;
    j       = 3'd0;
    in_text = !over_q && (c != 8'h00) && (pos_q < PosW'(TextBufSize - 1));

    if (!over_q && !in_text) begin
      over_d = 1'b1;
      if (phase_q != PhDone) begin
        res_o.done_res = 1'b1;
        phase_d        = PhDone;
      end
    end else if (in_text) begin
      pos_d = pos_q + 1'b1;
      case (phase_q)
        PhKey: begin
          // partial-match fallback: a quote restarts the match; after "DATA" a 'D' does too
          if (match_q != 3'd0 && c == key_char(match_q)) begin
            j = match_q + 3'd1;
          end else if (match_q == 3'd6 && c == ChD) begin
            j = 3'd2;
          end else if (c == ChQuote) begin
            j = 3'd1;
          end else begin
            j = 3'd0;
          end
          if (j == 3'(KeyLen)) begin
            phase_d = PhSpace;
            match_d = 3'd0;
          end else begin
            match_d = j;
          end
        end
        PhSpace: begin
          if (c == ChOpen) begin
            phase_d = PhCopy;
          end else if (c != ChSpace) begin
            res_o.done_res = 1'b1;
            phase_d        = PhDone;
          end
        end
        default: ;
      endcase

      if (phase_d == PhCopy) begin
        if (c == ChOpen) begin
          depth_d = depth_q + 1'b1;
        end else if (c == ChClose) begin
          if (depth_q != '0) depth_d = depth_q - 1'b1;
          closed = (depth_d == '0);
        end
        if (kept_q < KeptW'(PayloadCap - 1)) begin
          res_o.payload_valid = 1'b1;
          res_o.payload_byte  = c;
          res_o.payload_index = 8'(kept_q);
          kept_d              = kept_q + 1'b1;
        end
        if (closed) begin
          res_o.done_res       = 1'b1;
          res_o.found          = 1'b1;
          res_o.payload_length = 8'(kept_d);
          phase_d              = PhDone;
        end
      end
    end

    if (item_i.frame_end) begin
      if (phase_d != PhDone) res_o.done_res = 1'b1;
      phase_d = PhKey;
      match_d = '0;
      depth_d = '0;
      kept_d  = '0;
      pos_d   = '0;
      over_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhKey;
      match_q <= '0;
      depth_q <= '0;
      kept_q  <= '0;
      pos_q   <= '0;
      over_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      match_q <= match_d;
      depth_q <= depth_d;
      kept_q  <= kept_d;
      pos_q   <= pos_d;
      over_q  <= over_d;
    end
  end

endmodule

/* rtl/jdoe_out_reg.sv */
module jdoe_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  jdoe_pkg::jdoe_out_t res_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output jdoe_pkg::jdoe_out_t out_data_o
);
  import jdoe_pkg::*;

  logic      valid_q, valid_d;
  jdoe_out_t data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* rtl/json_data_object_extractor.sv */
// JSON "DATA" object extractor.
// Input channel (in_valid_i / in_stall_o / in_data_i): one text byte per item,
// frame_end set on the last byte of a snapshot. Output channel (out_valid_o /
// out_stall_i / out_data_o): exactly one result item per input item, in order.
// The scanner looks for the key "DATA": , skips spaces, requires '{' and then
// forwards every byte up to the matching '}' with payload_valid and its index
// (at most PayloadCap-1 bytes kept). done_res is set once per snapshot, with
// found and payload_length telling the outcome.
// The result of an item is registered and appears at out_valid_o in the cycle
// after it is accepted. One item per cycle while in_stall_o is low; the scan state update
// is a single registered step per byte.
// The result register is the only buffer: in_stall_o rises only while a result
// is held and the receiver stalls, so with an idle receiver items flow every
// cycle. A stalled result holds its value until taken.
// Reset (rst_ni low, asynchronous) empties the result register and returns the
// scanner to key search at the start of a snapshot.
`include "json_data_object_extractor_defines.svh"

module json_data_object_extractor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  jdoe_pkg::jdoe_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output jdoe_pkg::jdoe_out_t out_data_o
);
  import jdoe_pkg::*;

  logic      step;
  jdoe_out_t res;

  // Stall only when the result register is full and cannot drain this cycle.
  assign in_stall_o = out_valid_o && out_stall_i;
  assign step       = in_valid_i && !in_stall_o;

  // Per-byte scan state and result logic.
  jdoe_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_data_i),
    .res_o  (res)
  );

  // Result register toward the receiver.
  jdoe_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `JDOE_ASSERT(a_stall_only_when_full, in_stall_o |-> out_valid_o)
  `JDOE_ASSERT(a_found_with_done, (out_valid_o && out_data_o.found) |-> out_data_o.done_res)
  `JDOE_ASSERT(a_length_with_found,
               (out_valid_o && out_data_o.payload_length != 8'd0) |-> out_data_o.found)
  `JDOE_ASSERT_ALWAYS(a_empty_in_reset, !rst_ni |-> !out_valid_o)

endmodule
